[sv/msws_pkg.sv]
// ----------------------------------------------------------------------------
// msws_pkg: shared types and codes for the multi-slot wake scheduler
// Transaction payloads for both channels and the opcode values.
// ----------------------------------------------------------------------------
package msws_pkg;

  localparam logic [2:0] OP_TICK          = 3'd0;
  localparam logic [2:0] OP_PROG_INTERVAL = 3'd1;
  localparam logic [2:0] OP_PROG_ONESHOT  = 3'd2;
  localparam logic [2:0] OP_DISABLE       = 3'd3;
  localparam logic [2:0] OP_QUERY         = 3'd4;

  localparam logic [31:0] DELAY_SAT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] now_ms;
    logic [7:0]  slot;
    logic [31:0] source_mask;
    logic [31:0] interval_ms;
    logic        due_now;
    logic [63:0] due_at_ms;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] due_mask;
    logic [31:0] next_delay_ms;
    logic        any_enabled;
  } out_t;

endpackage

[sv/multi_slot_wake_scheduler.sv]
// ----------------------------------------------------------------------------
// multi_slot_wake_scheduler: table of periodic and one-shot wake slots
// Sequencer over a slot table with one shared remainder unit for catch-up.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one opcode per
//   transaction: tick, program interval, program one-shot, disable, query.
//   Output channel (out_valid/out_stall/out_data) returns exactly one result
//   per input transaction, in order.
//   Each repeating slot that comes due on a tick adds a catch-up step
//   in the shared restoring remainder unit, one quotient bit a cycle.
//   The slot table is scanned one entry at a time through a single
//   registered read port.
//   in_stall is high while a transaction is being worked on; one item at a
//   time. A finished result sits in the output register; while out_stall is
//   high the sequencer holds the next result until the register frees up.
//   Reset (rst, synchronous) disables every slot and empties the output
//   register; table contents are only read behind their enable bits, so
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_slot_wake_scheduler #(
  parameter int SLOT_COUNT = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  msws_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output msws_pkg::out_t  out_data
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

  typedef struct packed {
    logic [31:0] mask;
    logic [63:0] due;
    logic [31:0] interval;
    logic        repeating;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_APPLY, S_RD, S_EVAL, S_DIV, S_FIX1, S_FIX2, S_MINUP,
    S_NEXT, S_DELAY, S_OUT
  } state_t;

  state_t                 state;
  msws_pkg::in_t          item;
  logic [SLOT_COUNT-1:0]  enabled;
  logic [IW-1:0]          scan_idx;
  logic                   acc;
  logic [31:0]            dmask;
  logic                   found;
  logic [63:0]            earliest;
  logic [63:0]            lag;
  logic [31:0]            rem;
  logic [5:0]             div_cnt;
  logic [63:0]            fix_base;
  logic                   bump;
  logic [63:0]            cur_due;
  logic [31:0]            res_delay;

  entry_t                 mem [SLOT_COUNT];
  entry_t                 rd_entry;
  logic                   wr_en;
  logic [IW-1:0]          wr_addr;
  entry_t                 wr_entry;

  logic                   in_range;
  logic [IW-1:0]          item_idx;
  logic                   prog_iv_ok;
  logic                   prog_os_ok;
  logic [32:0]            div_trial;
  logic [32:0]            div_sub;
  logic                   div_ge;
  logic [32:0]            step;
  logic [63:0]            new_due;
  logic [63:0]            delay_diff;

  assign in_range   = item.slot < 8'(SLOT_COUNT);
  assign item_idx   = item.slot[IW-1:0];
  assign prog_iv_ok = in_range && (item.source_mask != 32'd0) && (item.interval_ms != 32'd0);
  assign prog_os_ok = in_range && (item.source_mask != 32'd0);

  // restoring remainder step: one dividend bit per cycle
  assign div_trial = {rem, lag[63]};
  assign div_ge    = div_trial >= {1'b0, rd_entry.interval};
  assign div_sub   = div_trial - {1'b0, rd_entry.interval};

  // new due = now - r + iv (+ iv again when r + iv/2 reaches iv)
  assign step    = bump ? {rd_entry.interval, 1'b0} : {1'b0, rd_entry.interval};
  assign new_due = fix_base + {31'd0, step};

  assign delay_diff = earliest - item.now_ms;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = scan_idx;
    wr_entry = rd_entry;
    if (state == S_APPLY) begin
      wr_addr            = item_idx;
      wr_entry.mask      = item.source_mask;
      if (item.opcode == msws_pkg::OP_PROG_INTERVAL) begin
        wr_en              = prog_iv_ok;
        wr_entry.interval  = item.interval_ms;
        wr_entry.due       = item.now_ms + (item.due_now ? 64'd0 : {32'd0, item.interval_ms});
        wr_entry.repeating = 1'b1;
      end else begin
        wr_en              = (item.opcode == msws_pkg::OP_PROG_ONESHOT) && prog_os_ok;
        wr_entry.interval  = 32'd0;
        wr_entry.due       = item.due_at_ms;
        wr_entry.repeating = 1'b0;
      end
    end else if (state == S_FIX2) begin
      wr_en        = 1'b1;
      wr_entry.due = new_due;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      enabled   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          dmask    <= 32'd0;
          found    <= 1'b0;
          earliest <= 64'd0;
          scan_idx <= '0;
          state    <= S_RD;
          unique case (item.opcode)
            msws_pkg::OP_TICK:  acc <= 1'b1;
            msws_pkg::OP_QUERY: acc <= 1'b1;
            msws_pkg::OP_PROG_INTERVAL: begin
              acc <= prog_iv_ok;
              if (prog_iv_ok) enabled[item_idx] <= 1'b1;
            end
            msws_pkg::OP_PROG_ONESHOT: begin
              acc <= prog_os_ok;
              if (prog_os_ok) enabled[item_idx] <= 1'b1;
            end
            msws_pkg::OP_DISABLE: begin
              acc <= in_range;
              if (in_range) enabled[item_idx] <= 1'b0;
            end
            default: acc <= 1'b0;
          endcase
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          state <= S_NEXT;
          if (enabled[scan_idx]) begin
            if (item.opcode == msws_pkg::OP_TICK && item.now_ms >= rd_entry.due) begin
              dmask <= dmask | rd_entry.mask;
              if (rd_entry.repeating && rd_entry.interval != 32'd0) begin
                lag     <= item.now_ms - rd_entry.due;
                rem     <= 32'd0;
                div_cnt <= 6'd63;
                state   <= S_DIV;
              end else begin
                enabled[scan_idx] <= 1'b0;
              end
            end else if (!found || rd_entry.due < earliest) begin
              earliest <= rd_entry.due;
              found    <= 1'b1;
            end
          end
        end
        S_DIV: begin
          rem     <= div_ge ? div_sub[31:0] : div_trial[31:0];
          lag     <= {lag[62:0], 1'b0};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd0) begin
            state <= S_FIX1;
          end
        end
        S_FIX1: begin
          fix_base <= item.now_ms - {32'd0, rem};
          bump     <= ({1'b0, rem} + {2'b0, rd_entry.interval[31:1]})
                      >= {1'b0, rd_entry.interval};
          state    <= S_FIX2;
        end
        S_FIX2: begin
          cur_due <= new_due;
          state   <= S_MINUP;
        end
        S_MINUP: begin
          if (!found || cur_due < earliest) begin
            earliest <= cur_due;
            found    <= 1'b1;
          end
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (scan_idx == LAST_IDX) begin
            state <= S_DELAY;
          end else begin
            scan_idx <= scan_idx + 1'b1;
            state    <= S_RD;
          end
        end
        S_DELAY: begin
          if (found && item.now_ms < earliest) begin
            res_delay <= (delay_diff[63:32] != 32'd0) ? msws_pkg::DELAY_SAT
                                                      : delay_diff[31:0];
          end else begin
            res_delay <= 32'd1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.accepted      <= acc;
            out_data.due_mask      <= dmask;
            out_data.next_delay_ms <= res_delay;
            out_data.any_enabled   <= found;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // remainder always stays below the divisor during the divide
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < rd_entry.interval)
    else $error("remainder out of range");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt == 6'd0) |=> state == S_FIX1)
    else $error("divide did not finish after 64 steps");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_APPLY)
    else $error("accepted transaction not applied");

  a_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || !out_stall))
      |=> (out_valid && out_data.next_delay_ms != 32'd0 && state == S_IDLE))
    else $error("result not delivered or zero delay");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for multi_slot_wake_scheduler
// Drives ticks, slot programming, disables and queries through the valid/stall
// input channel, predicts each result from a cycle-free copy of the slot table
// and compares every field of the output transactions in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  // longest stretch without any transaction: sender gap + 8 catch-ups + stalls
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  msws_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  msws_pkg::out_t out_data;

  multi_slot_wake_scheduler #(.SLOT_COUNT(SLOTS)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predicted slot table
  logic [31:0] sl_mask[SLOTS];
  logic [63:0] sl_due[SLOTS];
  logic [31:0] sl_interval[SLOTS];
  logic        sl_enabled[SLOTS];
  logic        sl_repeat[SLOTS];

  msws_pkg::out_t expected_results[$];
  int   fail_count = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;
  int   stall_mode = 0;
  int   stall_left = 0;

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      sl_mask[i] = '0;
      sl_due[i] = '0;
      sl_interval[i] = '0;
      sl_enabled[i] = 1'b0;
      sl_repeat[i] = 1'b0;
    end
  end

  function automatic msws_pkg::out_t predict_wake(msws_pkg::in_t t);
    msws_pkg::out_t r;
    logic        in_range;
    logic        found;
    logic [2:0]  idx;
    logic [63:0] lag;
    logic [63:0] k;
    logic [63:0] iv;
    logic [63:0] earliest;
    logic [63:0] delta;
    r = '0;
    r.next_delay_ms = 32'd1;
    in_range = t.slot < SLOTS;
    idx = t.slot[2:0];
    found = 1'b0;
    earliest = '0;
    case (t.opcode)
      msws_pkg::OP_TICK: begin
        r.accepted = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
          if (sl_enabled[i] && t.now_ms >= sl_due[i]) begin
            r.due_mask |= sl_mask[i];
            if (sl_repeat[i] && sl_interval[i] != 32'd0) begin
              // smallest whole number of intervals that lands past now + iv/2
              iv = {32'd0, sl_interval[i]};
              lag = t.now_ms - sl_due[i];
              k = lag / iv + ((lag % iv) + (iv >> 1)) / iv + 64'd1;
              sl_due[i] = sl_due[i] + k * iv;
            end else begin
              sl_enabled[i] = 1'b0;
            end
          end
        end
      end
      msws_pkg::OP_PROG_INTERVAL: begin
        if (in_range && t.source_mask != 32'd0 && t.interval_ms != 32'd0) begin
          sl_mask[idx] = t.source_mask;
          sl_interval[idx] = t.interval_ms;
          sl_due[idx] = t.due_now ? t.now_ms : t.now_ms + {32'd0, t.interval_ms};
          sl_enabled[idx] = 1'b1;
          sl_repeat[idx] = 1'b1;
          r.accepted = 1'b1;
        end
      end
      msws_pkg::OP_PROG_ONESHOT: begin
        if (in_range && t.source_mask != 32'd0) begin
          sl_mask[idx] = t.source_mask;
          sl_interval[idx] = 32'd0;
          sl_due[idx] = t.due_at_ms;
          sl_enabled[idx] = 1'b1;
          sl_repeat[idx] = 1'b0;
          r.accepted = 1'b1;
        end
      end
      msws_pkg::OP_DISABLE: begin
        if (in_range) begin
          sl_enabled[idx] = 1'b0;
          r.accepted = 1'b1;
        end
      end
      msws_pkg::OP_QUERY: r.accepted = 1'b1;
      default: r.accepted = 1'b0;
    endcase
    for (int i = 0; i < SLOTS; i++) begin
      if (sl_enabled[i] && (!found || sl_due[i] < earliest)) begin
        earliest = sl_due[i];
        found = 1'b1;
      end
    end
    if (found && t.now_ms < earliest) begin
      delta = earliest - t.now_ms;
      r.next_delay_ms = (delta > {32'd0, msws_pkg::DELAY_SAT}) ? msws_pkg::DELAY_SAT
                                                               : delta[31:0];
    end
    r.any_enabled = found;
    return r;
  endfunction

  function automatic msws_pkg::in_t make_item(logic [2:0] op, logic [63:0] now,
                                              logic [7:0] slot, logic [31:0] mask,
                                              logic [31:0] iv, logic dn,
                                              logic [63:0] due_at);
    msws_pkg::in_t t;
    t.opcode = op;
    t.now_ms = now;
    t.slot = slot;
    t.source_mask = mask;
    t.interval_ms = iv;
    t.due_now = dn;
    t.due_at_ms = due_at;
    return t;
  endfunction

  // one input transaction; the sender runs in bursts with random gaps
  task automatic send_item(input msws_pkg::in_t item);
    int gap;
    in_data <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    expected_results.push_back(predict_wake(item));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 6);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(50, 120);
        default: gap = $urandom_range(1, 40);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic test_empty_table();
    send_item(make_item(msws_pkg::OP_QUERY, 64'd0, 8'd0, 32'd0, 32'd0, 1'b0, 64'd0));
    send_item(make_item(msws_pkg::OP_TICK, '1, 8'd0, 32'd0, 32'd0, 1'b0, 64'd0));
    send_item(make_item(msws_pkg::OP_DISABLE, 64'd5, 8'd0, 32'd0, 32'd0, 1'b0, 64'd0));
  endtask

  task automatic test_rejects();
    send_item(make_item(msws_pkg::OP_PROG_INTERVAL, 64'd10, 8'(SLOTS), 32'd1, 32'd1, 1'b0,
                        64'd0));
    send_item(make_item(msws_pkg::OP_PROG_INTERVAL, 64'd10, 8'hFF, '1, '1, 1'b1, 64'd0));
    send_item(make_item(msws_pkg::OP_PROG_INTERVAL, 64'd10, 8'd2, 32'd0, 32'd50, 1'b0,
                        64'd0));
    send_item(make_item(msws_pkg::OP_PROG_INTERVAL, 64'd10, 8'd2, 32'd4, 32'd0, 1'b1,
                        64'd0));
    send_item(make_item(msws_pkg::OP_PROG_ONESHOT, 64'd10, 8'd200, 32'd1, 32'd0, 1'b0,
                        64'd20));
    send_item(make_item(msws_pkg::OP_PROG_ONESHOT, 64'd10, 8'd1, 32'd0, 32'd9, 1'b0,
                        64'd20));
    send_item(make_item(msws_pkg::OP_DISABLE, 64'd10, 8'(SLOTS), 32'd0, 32'd0, 1'b0,
                        64'd0));
  endtask

  task automatic test_unused_opcodes();
    for (int u = int'(msws_pkg::OP_QUERY) + 1; u < 8; u++)
      send_item(make_item(3'(u), 64'd10, 8'd0, '1, '1, 1'b1, '1));
  endtask

  task automatic test_catch_up_and_wrap();
    logic [63:0] top;
    top = 64'hFFFF_FFFF_FFFF_FF00;
    // far-future one-shot saturates the delay
    send_item(make_item(msws_pkg::OP_PROG_ONESHOT, 64'd0, 8'd7, '1, 32'd3, 1'b1, '1));
    send_item(make_item(msws_pkg::OP_PROG_INTERVAL, 64'd1000, 8'd0, 32'd1, 32'd100, 1'b0,
                        64'd0));
    send_item(make_item(msws_pkg::OP_TICK, 64'd1099, 8'd0, 32'd0, 32'd0, 1'b0, 64'd0));
    send_item(make_item(msws_pkg::OP_TICK, 64'd1100, 8'd0, 32'd0, 32'd0, 1'b0, 64'd0));
    send_item(make_item(msws_pkg::OP_TICK, 64'd1000149, 8'd0, 32'd0, 32'd0, 1'b0, 64'd0));
    // due right now near the top of the time range; catch-up wraps past 2^64
    send_item(make_item(msws_pkg::OP_PROG_INTERVAL, top, 8'd3, 32'h8000_0000, '1, 1'b1,
                        64'd0));
    send_item(make_item(msws_pkg::OP_TICK, top, 8'd0, 32'd0, 32'd0, 1'b0, 64'd0));
    // one-shot already in the past, then fired and retired
    send_item(make_item(msws_pkg::OP_PROG_ONESHOT, 64'd500, 8'd5, 32'h0000_0F00, 32'd0,
                        1'b0, 64'd495));
    send_item(make_item(msws_pkg::OP_TICK, 64'd500, 8'd0, 32'd0, 32'd0, 1'b0, 64'd0));
    send_item(make_item(msws_pkg::OP_DISABLE, 64'd500, 8'd7, 32'd0, 32'd0, 1'b0, 64'd0));
    send_item(make_item(msws_pkg::OP_PROG_INTERVAL, 64'd500, 8'd1, 32'h0001_0000, 32'd1,
                        1'b1, 64'd0));
    send_item(make_item(msws_pkg::OP_QUERY, 64'd501, 8'd0, 32'd0, 32'd0, 1'b0, 64'd0));
  endtask

  // mostly well-formed traffic on a moving clock, some malformed requests
  task automatic test_random_schedule(input int count);
    logic [63:0] wall;
    logic [63:0] due_at;
    logic [31:0] iv;
    logic [31:0] mask;
    logic [7:0]  slot;
    logic [2:0]  op;
    int          pick;
    int          n;
    case ($urandom_range(0, 2))
      0:       wall = 64'($urandom_range(0, 100000));
      1:       wall = {$urandom, $urandom};
      default: wall = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 20000));
    endcase
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3)
        wall = {$urandom, $urandom};
      else if (pick < 10)
        wall += 64'($urandom_range(0, 1 << 20));
      else
        wall += 64'($urandom_range(0, 40));
      slot = 8'($urandom_range(0, SLOTS - 1));
      mask = ($urandom_range(0, 1) == 0) ? 32'd1 << $urandom_range(0, 31) : $urandom;
      if (mask == 32'd0)
        mask = 32'd1;
      iv = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(1, 120));
      if (iv == 32'd0)
        iv = 32'd1;
      due_at = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                             : wall + 64'($urandom_range(0, 300)) - 64'd50;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        op = msws_pkg::OP_TICK;
      end else if (pick < 63) begin
        op = msws_pkg::OP_PROG_INTERVAL;
      end else if (pick < 75) begin
        op = msws_pkg::OP_PROG_ONESHOT;
      end else if (pick < 83) begin
        op = msws_pkg::OP_DISABLE;
      end else if (pick < 93) begin
        op = msws_pkg::OP_QUERY;
      end else begin
        case ($urandom_range(0, 3))
          0:       op = msws_pkg::OP_PROG_INTERVAL;
          1:       op = msws_pkg::OP_PROG_ONESHOT;
          2:       op = msws_pkg::OP_DISABLE;
          default: op = 3'($urandom_range(int'(msws_pkg::OP_QUERY) + 1, 7));
        endcase
        case ($urandom_range(0, 2))
          0:       slot = 8'($urandom_range(SLOTS, 255));
          1:       mask = 32'd0;
          default: iv = 32'd0;
        endcase
      end
      send_item(make_item(op, wall, slot, mask, iv, 1'($urandom_range(0, 1)), due_at));
    end
  endtask

  task automatic test_random_noise(input int count);
    int n;
    for (n = 0; n < count; n++)
      send_item(make_item(3'($urandom_range(0, 7)), {$urandom, $urandom}, 8'($urandom),
                          $urandom, $urandom, 1'($urandom_range(0, 1)),
                          {$urandom, $urandom}));
  endtask

  // receiver stall pattern: off, sparse, heavy, or a periodic comb
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= (stall_left % 11) < 5;
    endcase
  end

  // result checker
  msws_pkg::out_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected: %h", out_data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_data.accepted);
          fail_count++;
        end
        if (out_data.due_mask !== want.due_mask) begin
          $error("due_mask: expected %h, got %h", want.due_mask, out_data.due_mask);
          fail_count++;
        end
        if (out_data.next_delay_ms !== want.next_delay_ms) begin
          $error("next_delay_ms: expected %0d, got %0d", want.next_delay_ms,
                 out_data.next_delay_ms);
          fail_count++;
        end
        if (out_data.any_enabled !== want.any_enabled) begin
          $error("any_enabled: expected %0d, got %0d", want.any_enabled,
                 out_data.any_enabled);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_rejects();
    test_unused_opcodes();
    test_catch_up_and_wrap();
    test_random_schedule(480);
    test_random_noise(150);
    test_random_schedule(480);
    test_random_noise(150);
    test_random_schedule(480);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
sv/msws_pkg.sv
sv/multi_slot_wake_scheduler.sv
tb/tb.sv
